@@ hdl/hms_clock_seven_segment_scan_defines.svh @@
// Assertion macros for the clock display block
`ifndef HMS_CLOCK_SEVEN_SEGMENT_SCAN_DEFINES_SVH
`define HMS_CLOCK_SEVEN_SEGMENT_SCAN_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define HMS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a consequence in the same cycle as its cause.
`define HMS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define HMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/hmsc_pkg.sv @@
// Types, codes, segment table and digit helpers for the clock display block
package hmsc_pkg;

  typedef enum logic [1:0] {
    OP_SECOND = 2'd0,
    OP_SCAN   = 2'd1,
    OP_LOAD   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  localparam logic [1:0] FMT_12H      = 2'd0;
  localparam logic [1:0] FMT_24H      = 2'd1;
  localparam logic [1:0] FMT_DISABLED = 2'd2;

  localparam logic [2:0] SCAN_LAST = 3'd5;
  localparam logic [4:0] HOUR_RESET = 5'd1;
  localparam logic [4:0] HOUR_12_MAX = 5'd12;
  localparam logic [4:0] HOUR_24_MAX = 5'd23;
  localparam logic [5:0] MIN_SEC_MAX = 6'd59;

  typedef struct packed {
    opcode_t    opcode;
    logic [4:0] load_hour;
    logic [5:0] load_minute;
    logic [5:0] load_second;
  } hms_in_t;

  typedef struct packed {
    logic [7:0] digit_enable;
    logic [7:0] segments;
    logic [4:0] hour_now;
    logic [5:0] minute_now;
    logic [5:0] second_now;
    logic       load_rejected;
  } hms_out_t;

  localparam logic [7:0] SEG_TABLE [10] = '{
    8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66,
    8'hB6, 8'hBE, 8'hE0, 8'hFE, 8'hF6
  };

  function automatic logic [3:0] tens_digit(input logic [5:0] v);
    logic [3:0] t;
    if (v >= 6'd60) begin
      t = 4'd6;
    end else if (v >= 6'd50) begin
      t = 4'd5;
    end else if (v >= 6'd40) begin
      t = 4'd4;
    end else if (v >= 6'd30) begin
      t = 4'd3;
    end else if (v >= 6'd20) begin
      t = 4'd2;
    end else if (v >= 6'd10) begin
      t = 4'd1;
    end else begin
      t = 4'd0;
    end
    return t;
  endfunction

  function automatic logic [3:0] units_digit(input logic [5:0] v);
    logic [3:0] t;
    logic [5:0] r;
    t = tens_digit(v);
    r = v - {t[2:0], 3'b000} - {2'b00, t[2:0], 1'b0};
    return r[3:0];
  endfunction

endpackage

@@ hdl/hms_clock_seven_segment_scan.sv @@
// Hours-minutes-seconds clock with six-digit multiplexed seven-segment scan
//
//   port group        dir  handshake             payload
//   in_*              in   in_valid / in_ready   in_data (hms_in_t)
//   out_*             out  out_valid / out_ready out_data (hms_out_t)
//   cfg_write_*       in   cfg_write_enable      cfg_write_data (clock format)
//
// One item per cycle while out_ready does not stall; each item reaches out_data through
// the input register, then the result register that the time update feeds.
// Reset: time 1:00:00, scan on seconds units, twelve-hour format, both stages empty.
// A stalled result holds in the output register; the input register takes one
// more item, and in_ready drops only while both stages are full and stalled.
`include "hms_clock_seven_segment_scan_defines.svh"

module hms_clock_seven_segment_scan (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  hmsc_pkg::hms_in_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hmsc_pkg::hms_out_t out_data,
  input  logic              cfg_write_enable,
  input  logic [1:0]        cfg_write_data
);
  import hmsc_pkg::*;

  logic [1:0] clock_format;
  logic [4:0] hour_count;
  logic [5:0] minute_count;
  logic [5:0] second_count;
  logic [2:0] scan_position;

  logic [4:0] hour_count_next;
  logic [5:0] minute_count_next;
  logic [5:0] second_count_next;
  logic [2:0] scan_position_next;

  logic       s1_valid;
  hms_in_t    s1_data;
  hms_out_t   out_data_next;

  logic       out_free;
  logic       advance;
  logic       enabled;
  logic       load_ok;
  logic       rejected;
  logic [5:0] hour_wide;
  logic [3:0] digit;
  logic [7:0] enable_byte;

  assign out_free = !out_valid || out_ready;
  assign advance  = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;
  assign enabled  = (clock_format == FMT_12H) || (clock_format == FMT_24H);

  always_comb begin
    load_ok = enabled && (s1_data.load_minute <= MIN_SEC_MAX) &&
              (s1_data.load_second <= MIN_SEC_MAX);
    if (clock_format == FMT_12H) begin
      load_ok = load_ok && (s1_data.load_hour != 5'd0) &&
                (s1_data.load_hour <= HOUR_12_MAX);
    end else begin
      load_ok = load_ok && (s1_data.load_hour <= HOUR_24_MAX);
    end
  end

  // Next time and scan position for the item in the input register
  always_comb begin
    hour_count_next    = hour_count;
    minute_count_next  = minute_count;
    second_count_next  = second_count;
    scan_position_next = scan_position;
    rejected           = 1'b0;
    case (s1_data.opcode)
      OP_SECOND: begin
        if (enabled) begin
          if (second_count >= MIN_SEC_MAX) begin
            second_count_next = 6'd0;
            if (minute_count >= MIN_SEC_MAX) begin
              minute_count_next = 6'd0;
              if (clock_format == FMT_12H) begin
                if (hour_count >= HOUR_12_MAX || hour_count == 5'd0) begin
                  hour_count_next = 5'd1;
                end else begin
                  hour_count_next = hour_count + 5'd1;
                end
              end else begin
                if (hour_count >= HOUR_24_MAX) begin
                  hour_count_next = 5'd0;
                end else begin
                  hour_count_next = hour_count + 5'd1;
                end
              end
            end else begin
              minute_count_next = minute_count + 6'd1;
            end
          end else begin
            second_count_next = second_count + 6'd1;
          end
        end
      end
      OP_SCAN: begin
        if (enabled) begin
          scan_position_next = (scan_position >= SCAN_LAST) ? 3'd0 : scan_position + 3'd1;
        end
      end
      OP_LOAD: begin
        if (load_ok) begin
          hour_count_next   = s1_data.load_hour;
          minute_count_next = s1_data.load_minute;
          second_count_next = s1_data.load_second;
        end else begin
          rejected = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Digit shown at the scan position, from the updated time
  always_comb begin
    hour_wide = {1'b0, hour_count_next};
    case (scan_position_next)
      3'd1: begin
        digit       = tens_digit(second_count_next);
        enable_byte = 8'h40;
      end
      3'd2: begin
        digit       = units_digit(minute_count_next);
        enable_byte = 8'h20;
      end
      3'd3: begin
        digit       = tens_digit(minute_count_next);
        enable_byte = 8'h10;
      end
      3'd4: begin
        digit       = units_digit(hour_wide);
        enable_byte = 8'h08;
      end
      3'd5: begin
        digit       = tens_digit(hour_wide);
        enable_byte = 8'h04;
      end
      default: begin
        digit       = units_digit(second_count_next);
        enable_byte = 8'h80;
      end
    endcase
  end

  always_comb begin
    out_data_next.digit_enable  = enabled ? enable_byte : 8'h00;
    out_data_next.segments      = enabled ? SEG_TABLE[digit] : 8'h00;
    out_data_next.hour_now      = hour_count_next;
    out_data_next.minute_now    = minute_count_next;
    out_data_next.second_now    = second_count_next;
    out_data_next.load_rejected = rejected;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_format <= FMT_12H;
    end else if (cfg_write_enable) begin
      clock_format <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hour_count    <= HOUR_RESET;
      minute_count  <= 6'd0;
      second_count  <= 6'd0;
      scan_position <= 3'd0;
    end else if (advance) begin
      hour_count    <= hour_count_next;
      minute_count  <= minute_count_next;
      second_count  <= second_count_next;
      scan_position <= scan_position_next;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= out_data_next;
    end
  end

  `HMS_ASSERT_ALWAYS(a_time_range, (minute_count <= MIN_SEC_MAX) && (second_count <= MIN_SEC_MAX) && (scan_position <= SCAN_LAST), "time or scan position out of range")
  `HMS_ASSERT_SAME(a_enable_onehot, out_valid, $onehot0(out_data.digit_enable), "digit enable not one-hot")
  `HMS_ASSERT_NEXT(a_good_load, advance && (s1_data.opcode == OP_LOAD) && load_ok, (hour_count == $past(s1_data.load_hour)) && !out_data.load_rejected, "accepted load not applied")
  `HMS_ASSERT_NEXT(a_blank_disabled, advance && !enabled, (out_data.digit_enable == 8'h00) && (out_data.segments == 8'h00) && $stable(scan_position), "disabled display not blank")

endmodule

@@ verif/testbench.sv @@
// Self-checking bench for the six-digit clock display: random handshakes, predicted results
module testbench;
  import hmsc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  hms_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  hms_out_t out_data;
  logic     cfg_write_enable = 1'b0;
  logic [1:0] cfg_write_data = FMT_12H;

  hms_in_t  pending_items[$];
  hms_out_t expected_display[$];
  int       items_open = 0;
  int       results_seen = 0;
  int       mismatch_count = 0;
  int       cycle_count = 0;
  int       hold_left = 0;
  bit       long_hold_done = 1'b0;
  logic     in_taken = 1'b0;

  logic [1:0] fmt_q = FMT_12H;
  logic [4:0] hour_q = HOUR_RESET;
  logic [5:0] min_q = '0;
  logic [5:0] sec_q = '0;
  logic [2:0] scan_q = '0;

  hms_clock_seven_segment_scan uut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [7:0] glyph(input int d);
    case (d)
      0: return 8'hFC;
      1: return 8'h60;
      2: return 8'hDA;
      3: return 8'hF2;
      4: return 8'h66;
      5: return 8'hB6;
      6: return 8'hBE;
      7: return 8'hE0;
      8: return 8'hFE;
      default: return 8'hF6;
    endcase
  endfunction

  function automatic hms_out_t clock_advance(input hms_in_t it);
    hms_out_t r;
    logic live;
    logic good;
    int shown;
    live = (fmt_q == FMT_12H) || (fmt_q == FMT_24H);
    r = '0;
    case (it.opcode)
      OP_SECOND: begin
        if (live) begin
          if (sec_q >= MIN_SEC_MAX) begin
            sec_q = '0;
            if (min_q >= MIN_SEC_MAX) begin
              min_q = '0;
              if (fmt_q == FMT_12H)
                hour_q = (hour_q >= HOUR_12_MAX || hour_q == 5'd0) ? 5'd1 : hour_q + 5'd1;
              else
                hour_q = (hour_q >= HOUR_24_MAX) ? 5'd0 : hour_q + 5'd1;
            end else begin
              min_q = min_q + 6'd1;
            end
          end else begin
            sec_q = sec_q + 6'd1;
          end
        end
      end
      OP_SCAN: begin
        if (live) scan_q = (scan_q >= SCAN_LAST) ? 3'd0 : scan_q + 3'd1;
      end
      OP_LOAD: begin
        good = live && it.load_minute <= MIN_SEC_MAX && it.load_second <= MIN_SEC_MAX;
        if (fmt_q == FMT_12H)
          good = good && it.load_hour >= 5'd1 && it.load_hour <= HOUR_12_MAX;
        else
          good = good && it.load_hour <= HOUR_24_MAX;
        if (good) begin
          hour_q = it.load_hour;
          min_q = it.load_minute;
          sec_q = it.load_second;
        end else begin
          r.load_rejected = 1'b1;
        end
      end
      default: ;
    endcase
    if (live) begin
      case (scan_q)
        3'd0: shown = sec_q % 10;
        3'd1: shown = sec_q / 10;
        3'd2: shown = min_q % 10;
        3'd3: shown = min_q / 10;
        3'd4: shown = hour_q % 10;
        default: shown = hour_q / 10;
      endcase
      r.digit_enable = 8'h80 >> scan_q;
      r.segments = glyph(shown % 10);
    end
    r.hour_now = hour_q;
    r.minute_now = min_q;
    r.second_now = sec_q;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (mismatch_count < 40)
      $display("MISMATCH %s: expected %0d, got %0d (result %0d)", what, want, got,
               results_seen);
    mismatch_count++;
  endtask

  task automatic check_result(input hms_out_t want, input hms_out_t got);
    if (got.digit_enable !== want.digit_enable)
      report_mismatch("digit_enable", 32'(want.digit_enable), 32'(got.digit_enable));
    if (got.segments !== want.segments)
      report_mismatch("segments", 32'(want.segments), 32'(got.segments));
    if (got.hour_now !== want.hour_now)
      report_mismatch("hour_now", 32'(want.hour_now), 32'(got.hour_now));
    if (got.minute_now !== want.minute_now)
      report_mismatch("minute_now", 32'(want.minute_now), 32'(got.minute_now));
    if (got.second_now !== want.second_now)
      report_mismatch("second_now", 32'(want.second_now), 32'(got.second_now));
    if (got.load_rejected !== want.load_rejected)
      report_mismatch("load_rejected", 32'(want.load_rejected), 32'(got.load_rejected));
  endtask

  function automatic logic quiet_stretch();
    return cycle_count >= 1000 && cycle_count < 1500;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_taken)) begin
      if (pending_items.size() != 0 && (quiet_stretch() || $urandom_range(99) >= 30)) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (!rst) begin
      if (results_seen == 300 && !long_hold_done) begin
        hold_left = 150;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet_stretch() || ($urandom_range(99) >= 30);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) expected_display.push_back(clock_advance(in_data));
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_display.size() == 0) begin
          report_mismatch("transfer with nothing expected", 32'd0, 32'(out_data.second_now));
        end else begin
          check_result(expected_display.pop_front(), out_data);
          items_open--;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic hms_in_t mk(input opcode_t op, input logic [4:0] h,
                                 input logic [5:0] m, input logic [5:0] s);
    hms_in_t it;
    it.opcode = op;
    it.load_hour = h;
    it.load_minute = m;
    it.load_second = s;
    return it;
  endfunction

  function automatic hms_in_t random_item();
    hms_in_t it;
    int pick;
    it = mk(OP_NONE, 5'($urandom_range(31)), 6'($urandom_range(63)),
            6'($urandom_range(63)));
    pick = $urandom_range(99);
    if (pick < 40) begin
      it.opcode = OP_SECOND;
    end else if (pick < 68) begin
      it.opcode = OP_SCAN;
    end else if (pick < 95) begin
      it.opcode = OP_LOAD;
      if ($urandom_range(3) != 0) begin
        it.load_hour = (fmt_q == FMT_12H) ? 5'($urandom_range(12, 1))
                                          : 5'($urandom_range(23, 0));
        it.load_minute = ($urandom_range(1) != 0) ? MIN_SEC_MAX : 6'($urandom_range(59));
        it.load_second = 6'($urandom_range(59, 50));
      end
    end
    return it;
  endfunction

  task automatic queue_item(input hms_in_t it);
    pending_items.push_back(it);
    items_open++;
  endtask

  task automatic set_format(input logic [1:0] fmt);
    while (items_open != 0) @(negedge clk);
    cfg_write_data <= fmt;
    cfg_write_enable <= 1'b1;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    fmt_q = fmt;
  endtask

  task automatic queue_random(input int count);
    repeat (count) queue_item(random_item());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_format(FMT_12H);
    repeat (6) queue_item(mk(OP_SCAN, 5'd0, 6'd0, 6'd0));
    queue_item(mk(OP_LOAD, 5'd12, 6'd59, 6'd59));
    queue_item(mk(OP_SECOND, 5'd0, 6'd0, 6'd0));
    queue_item(mk(OP_LOAD, 5'd11, 6'd59, 6'd59));
    queue_item(mk(OP_SECOND, 5'd31, 6'd63, 6'd63));
    queue_item(mk(OP_LOAD, 5'd0, 6'd0, 6'd0));
    queue_item(mk(OP_LOAD, 5'd13, 6'd0, 6'd0));
    queue_item(mk(OP_LOAD, 5'd31, 6'd63, 6'd63));
    queue_item(mk(OP_LOAD, 5'd12, 6'd60, 6'd0));
    queue_item(mk(OP_LOAD, 5'd12, 6'd0, 6'd60));
    queue_item(mk(OP_LOAD, 5'd1, 6'd0, 6'd0));
    queue_item(mk(OP_NONE, 5'd31, 6'd63, 6'd63));

    set_format(FMT_24H);
    queue_item(mk(OP_LOAD, 5'd23, 6'd59, 6'd59));
    queue_item(mk(OP_SECOND, 5'd0, 6'd0, 6'd0));
    queue_item(mk(OP_LOAD, 5'd24, 6'd0, 6'd0));
    queue_item(mk(OP_LOAD, 5'd20, 6'd59, 6'd59));

    // hour left outside the twelve-hour range, then rollover
    set_format(FMT_12H);
    queue_item(mk(OP_SECOND, 5'd0, 6'd0, 6'd0));
    set_format(FMT_24H);
    queue_item(mk(OP_LOAD, 5'd0, 6'd59, 6'd59));
    set_format(FMT_12H);
    queue_item(mk(OP_SECOND, 5'd0, 6'd0, 6'd0));

    set_format(FMT_DISABLED);
    queue_item(mk(OP_SECOND, 5'd0, 6'd0, 6'd0));
    queue_item(mk(OP_SCAN, 5'd0, 6'd0, 6'd0));
    queue_item(mk(OP_LOAD, 5'd5, 6'd5, 6'd5));
    set_format(2'd3);
    queue_item(mk(OP_LOAD, 5'd1, 6'd0, 6'd0));
    queue_item(mk(OP_SECOND, 5'd0, 6'd0, 6'd0));

    set_format(FMT_12H);
    queue_random(380);
    set_format(FMT_24H);
    queue_random(380);
    set_format(FMT_DISABLED);
    queue_random(50);
    set_format(2'd3);
    queue_random(30);
    set_format(FMT_12H);
    queue_random(170);
    set_format(FMT_24H);
    queue_random(110);

    while (items_open != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (expected_display.size() != 0)
      report_mismatch("results never arrived", expected_display.size(), 0);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
